// ----- hw/rtl/hrp_pkg.sv -----
// Package for the HTTP request byte parser: parser codes, capacities,
// result item type and character tables. No dependencies.
`default_nettype none

package hrp_pkg;

  // Capacities (a kept count never exceeds capacity minus one)
  localparam int LINE_CAPACITY  = 128;
  localparam int PATH_CAPACITY  = 64;
  localparam int PARAM_CAPACITY = 128;
  localparam int LINE_W         = $clog2(LINE_CAPACITY);

  // Result kinds
  localparam logic [1:0] KIND_PATH      = 2'd0;
  localparam logic [1:0] KIND_PARAM     = 2'd1;
  localparam logic [1:0] KIND_COMPLETE  = 2'd2;
  localparam logic [1:0] KIND_MALFORMED = 2'd3;

  // Methods
  localparam logic [1:0] METH_UNKNOWN = 2'd0;
  localparam logic [1:0] METH_GET     = 2'd1;
  localparam logic [1:0] METH_POST    = 2'd2;

  // Input item types
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_CONN = 1'b1;

  // Parser phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_REQ  = 3'd1;
  localparam logic [2:0] PH_HDR  = 3'd2;
  localparam logic [2:0] PH_BODY = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  // Request line sub-phases
  localparam logic [2:0] UP_PREFIX = 3'd0;
  localparam logic [2:0] UP_SPACES = 3'd1;
  localparam logic [2:0] UP_PATH   = 3'd2;
  localparam logic [2:0] UP_QUERY  = 3'd3;
  localparam logic [2:0] UP_REST   = 3'd4;
  localparam logic [2:0] UP_BAD    = 3'd5;

  // Header match codes above the name-match positions
  localparam logic [4:0] HM_NAME_LEN = 5'd15;
  localparam logic [4:0] HM_OWS      = 5'd15;
  localparam logic [4:0] HM_SIGN     = 5'd16;
  localparam logic [4:0] HM_DIGITS   = 5'd17;
  localparam logic [4:0] HM_STOP     = 5'd18;
  localparam logic [4:0] HM_NONE     = 5'd31;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  method;
    logic [15:0] body_length;
    logic [5:0]  path_length;
    logic [6:0]  params_length;
    logic        last_of_run;
  } hrp_res_t;

  // Results produced by one input item, handed to the output queue
  typedef struct packed {
    logic [1:0] count;
    hrp_res_t   res0;
    hrp_res_t   res1;
  } hrp_push_t;

  function automatic logic [7:0] get_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "G";
      3'd1:    ch = "E";
      3'd2:    ch = "T";
      3'd3:    ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] post_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "P";
      3'd1:    ch = "O";
      3'd2:    ch = "S";
      3'd3:    ch = "T";
      3'd4:    ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Lowercase "content-length:"
  function automatic logic [7:0] clen_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hrp_in_if.sv -----
// Input channel of the HTTP request byte parser: valid/ready plus
// the request item fields. No dependencies.
`default_nettype none

interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hrp_out_if.sv -----
// Result channel of the HTTP request byte parser: valid/ready plus
// the result item fields. No dependencies.
`default_nettype none

interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [1:0]  method;
  logic [15:0] body_length;
  logic [5:0]  path_length;
  logic [6:0]  params_length;
  logic        last_of_run;

  modport source (output valid, kind, out_byte, method, body_length, path_length,
                  params_length, last_of_run, input ready);
  modport sink   (input valid, kind, out_byte, method, body_length, path_length,
                  params_length, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/http_request_byte_parser.sv -----
// Top level of the HTTP request byte parser: parser core and result queue.
// Depends on hrp_pkg, hrp_in_if, hrp_out_if, hrp_core, hrp_out_fifo.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    req_type, data_byte
//   out_chan  out  valid/ready    kind, out_byte, method, body_length,
//                                 path_length, params_length, last_of_run
//
// One byte per cycle while the result queue has room: each item is registered,
// then parsed by combinational step logic into a four-entry result queue; most
// bytes yield zero or one result. A body byte that ends the body can yield two
// results, its byte and the completion, both written into the queue together.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the queue.
// Input stalls only when the queue holds more than two results.
`default_nettype none

module http_request_byte_parser
  import hrp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  hrp_in_if.sink     in_chan,
  hrp_out_if.source  out_chan
);

  hrp_push_t push;
  logic      space_ok;

  hrp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .space_ok (space_ok),
    .push     (push)
  );

  hrp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/hrp_core.sv -----
// Parser core: input register, per-byte parser state and step logic.
// Depends on hrp_pkg and hrp_in_if.
`default_nettype none

module hrp_core
  import hrp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  hrp_in_if.sink     in_chan,
  input  wire logic  space_ok,
  output hrp_push_t  push
);

  // Input register
  logic       in_valid_r;
  logic       type_r;
  logic [7:0] byte_r;
  logic       fire;

  // Parser state
  logic [2:0]        phase_r, phase_nxt;
  logic [1:0]        method_r, method_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              long_r, long_nxt;
  logic [2:0]        url_r, url_nxt;
  logic [4:0]        hm_r, hm_nxt;
  logic [15:0]       acc_r, acc_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [15:0]       body_r, body_nxt;
  logic [5:0]        path_r, path_nxt;
  logic [6:0]        param_r, param_nxt;

  // Step helpers
  logic [19:0] acc_ext;
  logic [1:0]  n_emit;
  logic [1:0]  k0, k1;
  logic [7:0]  b0, b1;
  logic [7:0]  c;
  logic [4:0]  hm_inc;

  assign fire          = in_valid_r && space_ok;
  assign in_chan.ready = !in_valid_r || fire;
  assign c             = byte_r;
  assign hm_inc        = hm_r + 5'd1;
  assign acc_ext       = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {12'd0, c - CH_0};

  // Hold the accepted item until the output queue has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      type_r <= in_chan.req_type;
      byte_r <= in_chan.data_byte;
    end
  end

  // Advance the parser by one item
  always_comb begin
    phase_nxt  = phase_r;
    method_nxt = method_r;
    line_nxt   = line_r;
    long_nxt   = long_r;
    url_nxt    = url_r;
    hm_nxt     = hm_r;
    acc_nxt    = acc_r;
    len_nxt    = len_r;
    body_nxt   = body_r;
    path_nxt   = path_r;
    param_nxt  = param_r;
    n_emit     = 2'd0;
    k0         = KIND_PATH;
    k1         = KIND_COMPLETE;
    b0         = 8'h00;
    b1         = 8'h00;

    if (!fire) begin
      // nothing to do
    end else if (type_r == REQ_CONN) begin
      phase_nxt  = PH_REQ;
      method_nxt = METH_UNKNOWN;
      line_nxt   = '0;
      long_nxt   = 1'b0;
      url_nxt    = UP_PREFIX;
      hm_nxt     = 5'd0;
      acc_nxt    = 16'd0;
      len_nxt    = 16'd0;
      body_nxt   = 16'd0;
      path_nxt   = 6'd0;
      param_nxt  = 7'd0;
    end else if (phase_r == PH_BODY) begin
      // Body byte, then completion when the count is reached
      if (param_r < 7'(PARAM_CAPACITY - 1)) begin
        param_nxt = param_r + 7'd1;
        n_emit    = 2'd1;
        k0        = KIND_PARAM;
        b0        = c;
      end
      body_nxt = body_r + 16'd1;
      if (body_nxt >= len_r) begin
        phase_nxt = PH_DONE;
        if (n_emit == 2'd0) begin
          n_emit = 2'd1;
          k0     = KIND_COMPLETE;
        end else begin
          n_emit = 2'd2;
        end
      end
    end else if (phase_r == PH_REQ || phase_r == PH_HDR) begin
      if (c == CH_CR) begin
        // drop
      end else if (c != CH_LF) begin
        if (line_r < LINE_W'(LINE_CAPACITY - 1)) begin
          line_nxt = line_r + LINE_W'(1);
          if (phase_r == PH_REQ) begin
            // Request line
            case (url_r)
              UP_PREFIX: begin
                if (hm_r == 5'd0) begin
                  if (c == CH_G) begin
                    method_nxt = METH_GET;
                    hm_nxt     = 5'd1;
                  end else if (c == CH_P) begin
                    method_nxt = METH_POST;
                    hm_nxt     = 5'd1;
                  end else begin
                    url_nxt = UP_BAD;
                  end
                end else if (method_r == METH_GET) begin
                  if (hm_r < 5'd4 && c == get_char(hm_r[2:0])) begin
                    hm_nxt = hm_inc;
                    if (hm_inc == 5'd4) begin
                      url_nxt = UP_SPACES;
                      hm_nxt  = 5'd0;
                    end
                  end else begin
                    url_nxt = UP_BAD;
                  end
                end else begin
                  if (hm_r < 5'd5 && c == post_char(hm_r[2:0])) begin
                    hm_nxt = hm_inc;
                    if (hm_inc == 5'd5) begin
                      url_nxt = UP_SPACES;
                      hm_nxt  = 5'd0;
                    end
                  end else begin
                    url_nxt = UP_BAD;
                  end
                end
              end
              UP_SPACES, UP_PATH: begin
                if (c == CH_SP) begin
                  if (url_r == UP_PATH) url_nxt = UP_REST;
                end else if (c == CH_QUEST) begin
                  url_nxt = UP_QUERY;
                end else begin
                  url_nxt = UP_PATH;
                  if (path_r < 6'(PATH_CAPACITY - 1)) begin
                    path_nxt = path_r + 6'd1;
                    n_emit   = 2'd1;
                    k0       = KIND_PATH;
                    b0       = c;
                  end
                end
              end
              UP_QUERY: begin
                if (c == CH_SP) begin
                  url_nxt = UP_REST;
                end else if (method_r == METH_GET &&
                             param_r < 7'(PARAM_CAPACITY - 1)) begin
                  param_nxt = param_r + 7'd1;
                  n_emit    = 2'd1;
                  k0        = KIND_PARAM;
                  b0        = c;
                end
              end
              default: begin
              end
            endcase
          end else begin
            // Header line: match the length header and read its value
            if (hm_r < HM_NAME_LEN) begin
              hm_nxt = (to_lower(c) == clen_char(hm_r[3:0])) ? hm_inc : HM_NONE;
            end else if (hm_r == HM_OWS || hm_r == HM_SIGN || hm_r == HM_DIGITS) begin
              if (hm_r == HM_OWS && (c == CH_SP || c == CH_TAB)) begin
                // skip white space
              end else if (hm_r == HM_OWS && c == CH_PLUS) begin
                hm_nxt = HM_SIGN;
              end else if (c >= CH_0 && c <= CH_9) begin
                acc_nxt = (acc_ext > 20'hFFFF) ? 16'hFFFF : acc_ext[15:0];
                hm_nxt  = HM_DIGITS;
              end else begin
                if (hm_r == HM_OWS && c == CH_MINUS) acc_nxt = 16'd0;
                hm_nxt = HM_STOP;
              end
            end
          end
        end else begin
          long_nxt = 1'b1;
        end
      end else if (phase_r == PH_REQ) begin
        // End of the request line
        if (url_r == UP_PREFIX || url_r == UP_BAD) begin
          method_nxt = METH_UNKNOWN;
          phase_nxt  = PH_DONE;
          n_emit     = 2'd1;
          k0         = KIND_MALFORMED;
        end else begin
          phase_nxt = PH_HDR;
          line_nxt  = '0;
          long_nxt  = 1'b0;
          hm_nxt    = 5'd0;
          acc_nxt   = 16'd0;
        end
      end else if (line_r == '0 && !long_r) begin
        // Blank line ends the headers
        if (method_r == METH_POST && len_r != 16'd0) begin
          body_nxt  = 16'd0;
          phase_nxt = PH_BODY;
        end else begin
          phase_nxt = PH_DONE;
          n_emit    = 2'd1;
          k0        = KIND_COMPLETE;
        end
      end else begin
        // End of a header line
        if (!long_r && hm_r >= HM_OWS && hm_r != HM_NONE) len_nxt = acc_r;
        line_nxt = '0;
        long_nxt = 1'b0;
        hm_nxt   = 5'd0;
        acc_nxt  = 16'd0;
      end
    end
  end

  // Results carry the state as it stands after this item
  always_comb begin
    push.count               = n_emit;
    push.res0.kind           = k0;
    push.res0.out_byte       = b0;
    push.res0.method         = method_nxt;
    push.res0.body_length    = len_nxt;
    push.res0.path_length    = path_nxt;
    push.res0.params_length  = param_nxt;
    push.res0.last_of_run    = (n_emit == 2'd1);
    push.res1.kind           = k1;
    push.res1.out_byte       = b1;
    push.res1.method         = method_nxt;
    push.res1.body_length    = len_nxt;
    push.res1.path_length    = path_nxt;
    push.res1.params_length  = param_nxt;
    push.res1.last_of_run    = 1'b1;
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      method_r <= METH_UNKNOWN;
      line_r   <= '0;
      long_r   <= 1'b0;
      url_r    <= UP_PREFIX;
      hm_r     <= 5'd0;
      acc_r    <= 16'd0;
      len_r    <= 16'd0;
      body_r   <= 16'd0;
      path_r   <= 6'd0;
      param_r  <= 7'd0;
    end else begin
      phase_r  <= phase_nxt;
      method_r <= method_nxt;
      line_r   <= line_nxt;
      long_r   <= long_nxt;
      url_r    <= url_nxt;
      hm_r     <= hm_nxt;
      acc_r    <= acc_nxt;
      len_r    <= len_nxt;
      body_r   <= body_nxt;
      path_r   <= path_nxt;
      param_r  <= param_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hrp_out_fifo.sv -----
// Four-entry result queue: takes up to two result items per cycle from
// the core and presents one at a time. Depends on hrp_pkg and hrp_out_if.
`default_nettype none

module hrp_out_fifo
  import hrp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hrp_push_t push,
  output logic           space_ok,
  hrp_out_if.source      out_chan
);

  hrp_res_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;
  hrp_res_t   head;

  assign space_ok = (cnt_r <= 3'd2);
  assign pop      = out_chan.valid && out_chan.ready;
  assign head     = mem_r[rp_r];

  // Present the oldest item
  assign out_chan.valid         = (cnt_r != 3'd0);
  assign out_chan.kind          = head.kind;
  assign out_chan.out_byte      = head.out_byte;
  assign out_chan.method        = head.method;
  assign out_chan.body_length   = head.body_length;
  assign out_chan.path_length   = head.path_length;
  assign out_chan.params_length = head.params_length;
  assign out_chan.last_of_run   = head.last_of_run;

  // Store new items
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wp_r] <= push.res0;
    if (push.count == 2'd2) mem_r[wp_r + 2'd1] <= push.res1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_r + push.count;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, push.count} - {2'b00, pop};
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_http_request_byte_parser.sv -----
// Testbench for http_request_byte_parser: drives request bytes, predicts
// every result item and checks it. Depends on hrp_pkg, hrp_in_if, hrp_out_if.
`timescale 1ns / 100ps

module tb_http_request_byte_parser;
  import hrp_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 10;
  localparam int N_RANDOM     = 1250;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 1000;
  localparam int MAX_REPORTS  = 40;

  // Request prefixes and header name the parser looks for
  localparam logic [31:0]  GET_TXT  = "GET ";
  localparam logic [39:0]  POST_TXT = "POST ";
  localparam logic [119:0] CLEN_TXT = "content-length:";

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_item_t;

  logic clk;
  logic rst_n;

  hrp_in_if  in_chan ();
  hrp_out_if out_chan ();

  http_request_byte_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #CLK_HALF clk = ~clk;

  req_item_t byte_q[$];          // request bytes waiting to be sent
  hrp_res_t  parse_results_q[$]; // results the parser owes us
  int        pushed;
  int        errors;
  int        reports;
  int        idle_cycles;

  // Shadow parser state
  logic [2:0]  p_phase;
  logic [1:0]  p_method;
  int          p_line_len;
  logic        p_line_long;
  logic [2:0]  p_url;
  logic [4:0]  p_match;
  int          p_acc;
  logic [15:0] p_clen;
  logic [15:0] p_body_cnt;
  logic [5:0]  p_path_cnt;
  logic [6:0]  p_param_cnt;

  // Results of the byte being parsed
  hrp_res_t step_res0;
  hrp_res_t step_res1;
  int       step_n;

  task automatic reset_parser();
    p_phase     = PH_IDLE;
    p_method    = METH_UNKNOWN;
    p_line_len  = 0;
    p_line_long = 1'b0;
    p_url       = UP_PREFIX;
    p_match     = '0;
    p_acc       = 0;
    p_clen      = '0;
    p_body_cnt  = '0;
    p_path_cnt  = '0;
    p_param_cnt = '0;
  endtask

  task automatic start_line();
    p_line_len  = 0;
    p_line_long = 1'b0;
    p_match     = '0;
    p_acc       = 0;
  endtask

  // Record one result using the current counters
  task automatic add_result(input logic [1:0] kind, input logic [7:0] b);
    hrp_res_t r;
    r.kind          = kind;
    r.out_byte      = b;
    r.method        = p_method;
    r.body_length   = p_clen;
    r.path_length   = p_path_cnt;
    r.params_length = p_param_cnt;
    r.last_of_run   = 1'b0;
    if (step_n == 0) step_res0 = r;
    else step_res1 = r;
    step_n++;
  endtask

  // Advance the shadow parser by one accepted item and queue its results
  task automatic parse_item(input logic rt, input logic [7:0] c);
    logic [7:0] lc;
    int         h;
    step_n = 0;
    h = int'(p_match);
    if (rt == REQ_CONN) begin
      reset_parser();
      p_phase = PH_REQ;
    end else if (p_phase == PH_BODY) begin
      if (p_param_cnt < PARAM_CAPACITY - 1) begin
        p_param_cnt++;
        add_result(KIND_PARAM, c);
      end
      p_body_cnt = p_body_cnt + 16'd1;
      if (p_body_cnt >= p_clen) begin
        p_phase = PH_DONE;
        add_result(KIND_COMPLETE, 8'h00);
      end
    end else if ((p_phase == PH_REQ || p_phase == PH_HDR) && c != CH_CR) begin
      if (c != CH_LF) begin
        if (p_line_len < LINE_CAPACITY - 1) begin
          p_line_len++;
          if (p_phase == PH_REQ) begin
            // Request line: method prefix, path, query
            case (p_url)
              UP_PREFIX: begin
                if (h == 0) begin
                  if (c == CH_G) begin
                    p_method = METH_GET;
                    p_match  = 5'd1;
                  end else if (c == CH_P) begin
                    p_method = METH_POST;
                    p_match  = 5'd1;
                  end else begin
                    p_url = UP_BAD;
                  end
                end else if (p_method == METH_GET) begin
                  if (h < 4 && c == GET_TXT[8*(3-h) +: 8]) begin
                    p_match = 5'(h + 1);
                    if (h + 1 == 4) begin
                      p_url   = UP_SPACES;
                      p_match = '0;
                    end
                  end else begin
                    p_url = UP_BAD;
                  end
                end else begin
                  if (h < 5 && c == POST_TXT[8*(4-h) +: 8]) begin
                    p_match = 5'(h + 1);
                    if (h + 1 == 5) begin
                      p_url   = UP_SPACES;
                      p_match = '0;
                    end
                  end else begin
                    p_url = UP_BAD;
                  end
                end
              end
              UP_SPACES, UP_PATH: begin
                if (c == CH_SP) begin
                  if (p_url == UP_PATH) p_url = UP_REST;
                end else if (c == CH_QUEST) begin
                  p_url = UP_QUERY;
                end else begin
                  p_url = UP_PATH;
                  if (p_path_cnt < PATH_CAPACITY - 1) begin
                    p_path_cnt++;
                    add_result(KIND_PATH, c);
                  end
                end
              end
              UP_QUERY: begin
                if (c == CH_SP) begin
                  p_url = UP_REST;
                end else if (p_method == METH_GET && p_param_cnt < PARAM_CAPACITY - 1) begin
                  p_param_cnt++;
                  add_result(KIND_PARAM, c);
                end
              end
              default: begin
              end
            endcase
          end else begin
            // Header line: match the length header name, then its number
            if (h < HM_NAME_LEN) begin
              lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
              p_match = (lc == CLEN_TXT[8*(14-h) +: 8]) ? 5'(h + 1) : HM_NONE;
            end else if (h == HM_OWS || h == HM_SIGN || h == HM_DIGITS) begin
              if (h == HM_OWS && (c == CH_SP || c == CH_TAB)) begin
                // skip whitespace before the value
              end else if (h == HM_OWS && c == CH_PLUS) begin
                p_match = HM_SIGN;
              end else if (c >= CH_0 && c <= CH_9) begin
                p_acc = p_acc * 10 + (c - CH_0);
                if (p_acc > 65535) p_acc = 65535;
                p_match = HM_DIGITS;
              end else begin
                if (h == HM_OWS && c == CH_MINUS) p_acc = 0;
                p_match = HM_STOP;
              end
            end
          end
        end else begin
          p_line_long = 1'b1;
        end
      end else if (p_phase == PH_REQ) begin
        // End of request line
        if (p_url == UP_PREFIX || p_url == UP_BAD) begin
          p_method = METH_UNKNOWN;
          p_phase  = PH_DONE;
          add_result(KIND_MALFORMED, 8'h00);
        end else begin
          p_phase = PH_HDR;
          start_line();
        end
      end else if (p_line_len == 0 && !p_line_long) begin
        // Blank line ends the headers
        if (p_method == METH_POST && p_clen > 0) begin
          p_body_cnt = '0;
          p_phase    = PH_BODY;
        end else begin
          p_phase = PH_DONE;
          add_result(KIND_COMPLETE, 8'h00);
        end
      end else begin
        if (!p_line_long && p_match >= HM_OWS && p_match != HM_NONE) p_clen = 16'(p_acc);
        start_line();
      end
    end
    // Flag the final result of this item and queue them
    if (step_n == 1) step_res0.last_of_run = 1'b1;
    if (step_n == 2) step_res1.last_of_run = 1'b1;
    if (step_n > 0) parse_results_q.push_back(step_res0);
    if (step_n > 1) parse_results_q.push_back(step_res1);
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic push_item(input logic rt, input logic [7:0] b);
    req_item_t it;
    it.req_type  = rt;
    it.data_byte = b;
    byte_q.push_back(it);
    pushed++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_item(REQ_DATA, s[i]);
  endtask

  task automatic end_line();
    if ($urandom_range(0, 1)) push_item(REQ_DATA, CH_CR);
    push_item(REQ_DATA, CH_LF);
  endtask

  // Printable byte that does not start a query
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7E));
    if (c == CH_QUEST) c = "_";
    return c;
  endfunction

  // Length header name with random letter case
  task automatic push_clen_name();
    string      s;
    logic [7:0] ch;
    int         i;
    s = "content-length:";
    for (i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
      push_item(REQ_DATA, ch);
    end
  endtask

  // One request: mostly well formed, with noise, overflow and aborted variants
  task automatic gen_request();
    int m;
    int len;
    int clen;
    int nbody;
    push_item(REQ_CONN, 8'($urandom_range(0, 255)));
    m = $urandom_range(0, 9);
    if (m < 4) begin
      push_text("GET ");
    end else if (m < 8) begin
      push_text("POST ");
    end else begin
      case ($urandom_range(0, 3))
        0: push_text("GEt ");
        1: push_text("POS");
        2: repeat ($urandom_range(1, 5)) push_item(REQ_DATA, 8'($urandom_range(0, 255)));
        default: begin
        end
      endcase
    end
    repeat ($urandom_range(0, 2)) push_item(REQ_DATA, CH_SP);

    // Path, now and then long enough to overflow the path or the line
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 8);
    repeat (len) begin
      if ($urandom_range(0, 30) == 0) push_item(REQ_DATA, 8'($urandom_range(0, 255)));
      else push_item(REQ_DATA, text_char());
    end
    if ($urandom_range(0, 1)) begin
      push_item(REQ_DATA, CH_QUEST);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 130) : $urandom_range(0, 10);
      repeat (len) push_item(REQ_DATA, text_char());
    end
    if ($urandom_range(0, 2) != 0) push_text(" HTTP/1.1");
    end_line();

    // Headers
    clen = 0;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          push_clen_name();
          repeat ($urandom_range(0, 2)) push_item(REQ_DATA, $urandom_range(0, 1) ? CH_SP : CH_TAB);
          if ($urandom_range(0, 4) == 0) push_item(REQ_DATA, CH_PLUS);
          clen = ($urandom_range(0, 14) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 6);
          if ($urandom_range(0, 3) == 0) push_item(REQ_DATA, CH_0);
          push_text($sformatf("%0d", clen));
          if ($urandom_range(0, 4) == 0) push_text(" ;x");
          end_line();
        end
        5: begin
          // negative, empty or non-numeric value
          push_clen_name();
          case ($urandom_range(0, 2))
            0: push_text(" -7");
            1: begin
            end
            default: push_text(" abc");
          endcase
          clen = 0;
          end_line();
        end
        6: begin
          // value that saturates
          push_clen_name();
          push_text("9");
          repeat ($urandom_range(4, 6)) push_item(REQ_DATA, 8'($urandom_range(CH_0, CH_9)));
          clen = 65535;
          end_line();
        end
        7: begin
          push_text("Host: h1");
          end_line();
        end
        8: begin
          push_text($urandom_range(0, 1) ? "Content-Lengt: 5" : "Content-Length 5");
          end_line();
        end
        default: begin
          // long header line, over capacity when it starts with the length header; ignored as a whole
          if ($urandom_range(0, 1)) begin
            push_clen_name();
            push_text("3");
          end
          repeat ($urandom_range(125, 135)) push_item(REQ_DATA, text_char());
          end_line();
        end
      endcase
    end

    // Drop some requests before the blank line
    if ($urandom_range(0, 11) == 0) return;
    end_line();

    // Body for POST, extra ignored bytes otherwise
    if (m >= 4 && m < 8) begin
      nbody = (clen > 1000) ? $urandom_range(0, 10) : clen + $urandom_range(0, 2);
      repeat (nbody) push_item(REQ_DATA, 8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) push_item(REQ_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  // Wait until every byte is sent and every owed result has come
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_chan.valid) @(posedge clk);
    while (parse_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------- driver ----------------

  int send_left;
  int gap_left;

  always @(posedge clk) begin
    req_item_t it;
    if (!rst_n) begin
      in_chan.valid     <= 1'b0;
      in_chan.req_type  <= REQ_DATA;
      in_chan.data_byte <= 8'h00;
      send_left = 1;
      gap_left  = 0;
      reset_parser();
    end else begin
      if (in_chan.valid && in_chan.ready) parse_item(in_chan.req_type, in_chan.data_byte);
      // Hold the item while it is stalled; otherwise advance
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          it = byte_q.pop_front();
          in_chan.valid     <= 1'b1;
          in_chan.req_type  <= it.req_type;
          in_chan.data_byte <= it.data_byte;
          if (send_left > 1) begin
            send_left--;
          end else begin
            send_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  int stall_mode;
  int stall_left;
  int stall_tick;

  always @(posedge clk) begin
    hrp_res_t got;
    hrp_res_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      idle_cycles = 0;
      stall_mode  = 0;
      stall_left  = 0;
      stall_tick  = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.kind          = out_chan.kind;
        got.out_byte      = out_chan.out_byte;
        got.method        = out_chan.method;
        got.body_length   = out_chan.body_length;
        got.path_length   = out_chan.path_length;
        got.params_length = out_chan.params_length;
        got.last_of_run   = out_chan.last_of_run;
        if (parse_results_q.size() == 0) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: expected no result, actual kind=%0d byte=%02h method=%0d", $time,
                     got.kind, got.out_byte, got.method);
          end
        end else begin
          want = parse_results_q.pop_front();
          if (got !== want) begin
            errors++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("%0t: expected kind=%0d byte=%02h method=%0d body_len=%0d path_len=%0d params_len=%0d last=%0d",
                       $time, want.kind, want.out_byte, want.method, want.body_length,
                       want.path_length, want.params_length, want.last_of_run);
              $display("%0t: actual   kind=%0d byte=%02h method=%0d body_len=%0d path_len=%0d params_len=%0d last=%0d",
                       $time, got.kind, got.out_byte, got.method, got.body_length,
                       got.path_length, got.params_length, got.last_of_run);
            end
          end
        end
      end

      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) idle_cycles = 0;
      else idle_cycles++;

      // Receiver stall pattern: always ready, coin flip, one in four, periodic drop
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0:       out_chan.ready <= 1'b1;
        1:       out_chan.ready <= 1'($urandom_range(0, 1));
        2:       out_chan.ready <= (stall_tick % 4 == 0);
        default: out_chan.ready <= (stall_tick % 7 >= 2);
      endcase
    end
  end

  // ---------------- watchdog ----------------

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------- sequence ----------------

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.req_type  = REQ_DATA;
    in_chan.data_byte = 8'h00;
    out_chan.ready    = 1'b0;
    errors            = 0;
    reports           = 0;
    pushed            = 0;
    idle_cycles       = 0;
    reset_parser();

    // Directed: bytes before any connection, extreme bytes in path and query,
    // CR stripping, bytes after completion, bad method, back-to-back connections
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, 8'hFF);
    push_item(REQ_CONN, 8'h00);
    push_text("GET /");
    push_item(REQ_DATA, 8'hFF);
    push_item(REQ_DATA, CH_QUEST);
    push_item(REQ_DATA, 8'h00);
    push_item(REQ_DATA, CH_SP);
    push_item(REQ_DATA, CH_CR);
    push_item(REQ_DATA, CH_LF);
    push_item(REQ_DATA, CH_CR);
    push_item(REQ_DATA, CH_LF);
    push_item(REQ_DATA, 8'h41);
    push_item(REQ_CONN, 8'hFF);
    push_text("P");
    push_item(REQ_DATA, CH_LF);
    push_item(REQ_CONN, 8'h5A);
    push_item(REQ_CONN, 8'h00);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Hold off the random part until the directed results are all in
    wait_drained();

    pushed = 0;
    while (pushed < N_RANDOM) gen_request();
    wait_drained();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_in_if.sv
hw/rtl/hrp_out_if.sv
hw/rtl/hrp_core.sv
hw/rtl/hrp_out_fifo.sv
hw/rtl/http_request_byte_parser.sv
tb/sv/tb_http_request_byte_parser.sv
